[rtl/oer_pkg.sv]
// ----------------------------------------------------------------------------
// oer_pkg: shared types and codes of the occupancy event reporter
// Widths, report kinds, register indexes and the structs passed between
// the top level and the rule engine.
// ----------------------------------------------------------------------------
package oer_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned RetryW    = 24;
  localparam int unsigned IdleW     = 24;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned KindW     = 2;

  // Report kinds
  localparam logic [KindW-1:0] KindOccupied = 2'd0;
  localparam logic [KindW-1:0] KindReleased = 2'd1;
  localparam logic [KindW-1:0] KindRetry    = 2'd2;
  localparam logic [KindW-1:0] KindIdle     = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRetry    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIdle     = 2'd2;

  // Register reset values
  localparam logic [DebounceW-1:0] DebounceRst = 16'd50;
  localparam logic [RetryW-1:0]    RetryRst    = 24'd2000;
  localparam logic [IdleW-1:0]     IdleRst     = 24'd10000;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ms;
    logic [RetryW-1:0]    retry_ms;
    logic [IdleW-1:0]     idle_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             sensor_level;
    logic             ack_arrived;
  } poll_t;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic             level;
    logic [TimeW-1:0] time_ms;
  } report_t;

endpackage

[rtl/oer_core.sv]
// ----------------------------------------------------------------------------
// oer_core: rule engine of the occupancy event reporter
// Holds the event state and evaluates one registered poll against the
// priority rules, giving at most one report and the next state.
// ----------------------------------------------------------------------------
module oer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  oer_pkg::poll_t    poll_i,
  input  oer_pkg::cfg_t     cfg_i,
  output oer_pkg::report_t  report_o
);

  logic                       prev_level_q, prev_level_d;
  logic                       awaiting_q, awaiting_d;
  logic                       active_q, active_d;
  logic                       ack_q, ack_d;
  logic [oer_pkg::TimeW-1:0]  edge_time_q, edge_time_d;
  logic [oer_pkg::TimeW-1:0]  send_time_q, send_time_d;
  logic [oer_pkg::TimeW-1:0]  idle_time_q, idle_time_d;

  logic [oer_pkg::TimeW-1:0]  edge_diff, send_diff, idle_diff;
  logic                       ack_l, fire_evt, fire_rel, fire_retry, fire_idle;
  logic                       level;

  // Elapsed times, modulo the timestamp width
  assign level     = poll_i.sensor_level;
  assign ack_l     = ack_q | poll_i.ack_arrived;
  assign edge_diff = poll_i.now_ms - edge_time_q;
  assign send_diff = poll_i.now_ms - send_time_q;
  assign idle_diff = poll_i.now_ms - idle_time_q;

  // Rules in priority order
  assign fire_evt = !level && prev_level_q && !awaiting_q && !active_q &&
                    (edge_diff > {{(oer_pkg::TimeW-oer_pkg::DebounceW){1'b0}},
                                  cfg_i.debounce_ms});
  assign fire_rel   = awaiting_q && ack_l;
  assign fire_retry = awaiting_q &&
                      (send_diff > {{(oer_pkg::TimeW-oer_pkg::RetryW){1'b0}},
                                    cfg_i.retry_ms});
  assign fire_idle  = !awaiting_q && level &&
                      (idle_diff > {{(oer_pkg::TimeW-oer_pkg::IdleW){1'b0}},
                                    cfg_i.idle_ms});

  // Select report and next state
  always_comb begin
    prev_level_d     = prev_level_q;
    awaiting_d       = awaiting_q;
    active_d         = active_q;
    ack_d            = ack_l;
    edge_time_d      = edge_time_q;
    send_time_d      = send_time_q;
    idle_time_d      = idle_time_q;
    report_o.valid   = 1'b0;
    report_o.kind    = oer_pkg::KindOccupied;
    report_o.level   = 1'b0;
    report_o.time_ms = poll_i.now_ms;
    if (fire_evt) begin
      edge_time_d    = poll_i.now_ms;
      send_time_d    = poll_i.now_ms;
      awaiting_d     = 1'b1;
      active_d       = 1'b1;
      prev_level_d   = 1'b0;
      ack_d          = 1'b0;
      report_o.valid = 1'b1;
    end else if (fire_rel) begin
      awaiting_d     = 1'b0;
      ack_d          = 1'b0;
      report_o.valid = 1'b1;
      report_o.kind  = oer_pkg::KindReleased;
      report_o.level = 1'b1;
    end else if (fire_retry) begin
      send_time_d    = poll_i.now_ms;
      report_o.valid = 1'b1;
      report_o.kind  = oer_pkg::KindRetry;
    end else begin
      // re-arm on a rising edge, then consider the idle report
      if (level && !prev_level_q) begin
        prev_level_d = 1'b1;
        active_d     = 1'b0;
      end
      if (fire_idle) begin
        idle_time_d    = poll_i.now_ms;
        report_o.valid = 1'b1;
        report_o.kind  = oer_pkg::KindIdle;
        report_o.level = 1'b1;
      end
    end
  end

  // Advance state once per processed poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b1;
      awaiting_q   <= 1'b0;
      active_q     <= 1'b0;
      ack_q        <= 1'b0;
      edge_time_q  <= '0;
      send_time_q  <= '0;
      idle_time_q  <= '0;
    end else if (step_i) begin
      prev_level_q <= prev_level_d;
      awaiting_q   <= awaiting_d;
      active_q     <= active_d;
      ack_q        <= ack_d;
      edge_time_q  <= edge_time_d;
      send_time_q  <= send_time_d;
      idle_time_q  <= idle_time_d;
    end
  end

  // An accepted event leaves the block waiting with a clear latch
  a_event_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && report_o.valid && report_o.kind == oer_pkg::KindOccupied
    |=> awaiting_q && active_q && !ack_q && !prev_level_q)
    else $error("event report did not arm the wait state");

  // A release consumes the latched acknowledge
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && report_o.valid && report_o.kind == oer_pkg::KindReleased
    |=> !awaiting_q && !ack_q)
    else $error("release report left the wait state set");

  // Accepted level and event-in-progress always move together
  a_level_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_level_q == !active_q)
    else $error("accepted level and event flag disagree");

endmodule

[rtl/occupancy_event_reporter.sv]
// ----------------------------------------------------------------------------
// occupancy_event_reporter: occupancy sensor poll to event report converter
// Input register, rule engine and output register with valid/ready channels.
// ----------------------------------------------------------------------------
// One poll is accepted every clock cycle while the output register is taken
// at once; a poll that gives no report moves on even when the output register
// is full. A poll is held in the input register, where the rule engine
// evaluates it and updates its state, and its report, if any, is loaded into
// the output register at the end of the cycle in which the poll is processed.
// The rate is set by the state update of the rule engine. The user must write
// registers through the plain write port only while no poll is in flight;
// the block itself does not enforce this.
module occupancy_event_reporter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // poll channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [oer_pkg::TimeW-1:0]       now_ms_i,
  input  logic                            sensor_level_i,
  input  logic                            ack_arrived_i,
  // register write port
  input  logic                            cfg_we_i,
  input  logic [oer_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [oer_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // report channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [oer_pkg::KindW-1:0]       report_kind_o,
  output logic                            reported_level_o,
  output logic [oer_pkg::TimeW-1:0]       report_time_ms_o
);

  oer_pkg::cfg_t     cfg_q;
  oer_pkg::poll_t    poll_q;
  oer_pkg::report_t  report;
  logic              poll_valid_q;
  logic              step;
  logic              out_free;
  logic              out_valid_q;
  logic [oer_pkg::KindW-1:0] kind_q;
  logic              level_q;
  logic [oer_pkg::TimeW-1:0] time_q;

  // Register writes; an unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= oer_pkg::DebounceRst;
      cfg_q.retry_ms    <= oer_pkg::RetryRst;
      cfg_q.idle_ms     <= oer_pkg::IdleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        oer_pkg::RegDebounce: cfg_q.debounce_ms <= cfg_wdata_i[oer_pkg::DebounceW-1:0];
        oer_pkg::RegRetry:    cfg_q.retry_ms    <= cfg_wdata_i[oer_pkg::RetryW-1:0];
        oer_pkg::RegIdle:     cfg_q.idle_ms     <= cfg_wdata_i[oer_pkg::IdleW-1:0];
        default: ;
      endcase
    end
  end

  // Process the held poll when it gives no report or its report has somewhere to go
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = poll_valid_q && (out_free || !report.valid);
  assign in_ready_o = !poll_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      poll_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      poll_q.now_ms       <= now_ms_i;
      poll_q.sensor_level <= sensor_level_i;
      poll_q.ack_arrived  <= ack_arrived_i;
    end
  end

  oer_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .poll_i   (poll_q),
    .cfg_i    (cfg_q),
    .report_o (report)
  );

  // Output register: load a new report, drop a taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && report.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && report.valid) begin
      kind_q  <= report.kind;
      level_q <= report.level;
      time_q  <= report.time_ms;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign report_kind_o    = kind_q;
  assign reported_level_o = level_q;
  assign report_time_ms_o = time_q;

endmodule
